// ===== src/mncp_pkg.sv =====
// Shared types and constants for the MIDI note and control-change parser.
// No dependencies; every other file of the block imports this package.
package mncp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned DataW  = 7;
    localparam int unsigned KindW  = 2;
    localparam int unsigned TdataW = 16;

    // Status nibbles of the message kinds that the parser follows.
    localparam logic [3:0] NIB_CC       = 4'hB;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

    // Event kinds reported on the output.
    localparam logic [KindW-1:0] EV_NOTE_ON  = 2'd0;
    localparam logic [KindW-1:0] EV_NOTE_OFF = 2'd1;
    localparam logic [KindW-1:0] EV_CC       = 2'd2;

    // Parser states, one-hot. The *1 states wait for the first data byte of a
    // pair, the *2 states for the second.
    typedef enum logic [6:0] {
        ST_IGNORE = 7'b0000001,
        ST_CC1    = 7'b0000010,
        ST_ON1    = 7'b0000100,
        ST_OFF1   = 7'b0001000,
        ST_CC2    = 7'b0010000,
        ST_ON2    = 7'b0100000,
        ST_OFF2   = 7'b1000000
    } t_parse_state;

    typedef struct packed {
        logic             valid;
        logic [KindW-1:0] kind;
        logic [DataW-1:0] key;
        logic [DataW-1:0] value;
    } t_evt;

endpackage

// ===== src/mncp_in_stage.sv =====
// Input register of the MIDI parser: holds one received byte word.
// Depends on mncp_pkg.
module mncp_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mncp_pkg::ByteW-1:0]  i_byte,
    input  logic                        i_advance,
    output logic                        o_valid,
    output logic [mncp_pkg::ByteW-1:0]  o_byte
);
    import mncp_pkg::*;

    logic             r_valid;
    logic [ByteW-1:0] r_byte;

    // The held word leaves in the same cycle that a new one may enter.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== src/mncp_parser.sv =====
// Running-status parser: state machine and first data byte of a pair.
// Decodes the held byte into at most one event. Depends on mncp_pkg.
module mncp_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [mncp_pkg::ByteW-1:0]  i_byte,
    input  logic                        i_advance,
    output mncp_pkg::t_evt              o_evt
);
    import mncp_pkg::*;

    t_parse_state     r_state, n_state;
    logic [DataW-1:0] r_first, n_first;
    logic [DataW-1:0] data;
    logic [3:0]       nib;

    assign data = i_byte[DataW-1:0];
    assign nib  = i_byte[ByteW-1:ByteW-4];

    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        o_evt.valid  = 1'b0;
        o_evt.kind   = EV_CC;
        o_evt.key    = r_first;
        o_evt.value  = data;
        if (i_byte[ByteW-1]) begin
            // A status byte drops any half-received pair.
            priority if (nib == NIB_CC) begin
                n_state = ST_CC1;
            end else if (nib == NIB_NOTE_ON) begin
                n_state = ST_ON1;
            end else if (nib == NIB_NOTE_OFF) begin
                n_state = ST_OFF1;
            end else begin
                n_state = ST_IGNORE;
            end
        end else begin
            unique case (r_state)
                ST_CC1: begin
                    n_first = data;
                    n_state = ST_CC2;
                end
                ST_ON1: begin
                    n_first = data;
                    n_state = ST_ON2;
                end
                ST_OFF1: begin
                    n_first = data;
                    n_state = ST_OFF2;
                end
                ST_CC2: begin
                    n_state     = ST_CC1;
                    o_evt.valid = i_valid;
                    o_evt.kind  = EV_CC;
                end
                ST_ON2: begin
                    // Velocity zero means note off.
                    n_state     = ST_ON1;
                    o_evt.valid = i_valid;
                    o_evt.kind  = (data != '0) ? EV_NOTE_ON : EV_NOTE_OFF;
                end
                ST_OFF2: begin
                    n_state     = ST_OFF1;
                    o_evt.valid = i_valid;
                    o_evt.kind  = EV_NOTE_OFF;
                end
                default: begin
                    n_state = ST_IGNORE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IGNORE;
            r_first <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    a_status_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_byte[ByteW-1]) |-> !o_evt.valid)
        else $error("status byte produced an event");

    a_cc_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_byte[ByteW-1] && r_state == ST_CC2) |=> r_state == ST_CC1)
        else $error("control change pair did not return to running status");

    a_note_on_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.kind == EV_NOTE_ON) |-> o_evt.value != '0)
        else $error("note on reported with zero velocity");

endmodule

// ===== src/mncp_out_stage.sv =====
// Result register of the MIDI parser: holds one event word for the consumer.
// Depends on mncp_pkg.
module mncp_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  mncp_pkg::t_evt  i_evt,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output mncp_pkg::t_evt  o_evt
);
    import mncp_pkg::*;

    logic r_valid;
    t_evt r_evt;

    // The slot can take a new event when empty or when its word leaves now.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt <= i_evt;
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded event not presented");

endmodule

// ===== src/midi_note_cc_parser.sv =====
// Top level of the MIDI note-on, note-off and control-change parser.
// Depends on mncp_pkg, mncp_in_stage, mncp_parser and mncp_out_stage.

// The block takes one received MIDI byte per input word and reports note on,
// note off and control change events on any channel, following running
// status: after one status byte, any number of data byte pairs each give an
// event. A note on with velocity zero is reported as a note off with value
// zero. Other status bytes, including system and real-time bytes, make the
// block drop data bytes until the next note or controller status. Values are
// raw 7-bit numbers. Each byte passes from an input register through the
// parser logic into a result register, so one byte is taken every cycle
// unless it stalls; an event is presented once its last byte leaves the input
// register. The rate is set only by the consumer: the input stalls only while
// the held byte makes an event and the full result register is not taken.
module midi_note_cc_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Event words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] key_or_controller, [13:7] data_value,
                                        // [15:14] zero
    output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);
    import mncp_pkg::*;

    logic             in_valid;
    logic [ByteW-1:0] in_byte;
    logic             advance;
    logic             out_free;
    t_evt             evt;
    t_evt             out_evt;

    // The held byte moves on unless it makes an event and the result slot
    // is still occupied.
    assign advance = in_valid && (!evt.valid || out_free);

    mncp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    mncp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_valid),
        .i_byte    (in_byte),
        .i_advance (advance),
        .o_evt     (evt)
    );

    mncp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && evt.valid),
        .i_evt   (evt),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_evt   (out_evt)
    );

    assign m_axis_tdata = {{(TdataW - 2 * DataW){1'b0}}, out_evt.value, out_evt.key};
    assign m_axis_tuser = out_evt.kind;

endmodule
